// ----- rtl/ewse_pkg.sv -----
// Package of types, constants and widths shared by the wheel speed estimator.
`timescale 1ns / 1ps

package ewse_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int TIME_W     = 32;
  localparam int SPEED_W    = 21;
  localparam int NOISE_W    = 10;
  localparam int RADIUS_W   = 20;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 1;
  localparam int COUNT_W    = 2;
  localparam int POS_W      = SAMPLE_W + COUNT_W;
  localparam int NUM_W      = 16;
  localparam int MAG_W      = 14;
  localparam int SCALE_W    = 27;
  localparam int PROD_W     = RADIUS_W + MAG_W;
  localparam int N_W        = PROD_W + SCALE_W;
  localparam int DROP_W     = 14 + SAMPLE_W - 1;
  localparam int DVD_W      = N_W - DROP_W;
  localparam int Q2_W       = 23;
  localparam int CNT_W      = 6;

  localparam logic [SCALE_W-1:0] SCALE = 27'd102944000;

  localparam logic [CFG_IDX_W-1:0] REG_NOISE_OFFSET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_RADIUS = 1'b1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 2'd3;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [TIME_W-1:0]   timestamp_us;
  } sample_word_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0] speed_mm_s;
    logic                      bad_interval;
  } speed_word_t;

  typedef struct packed {
    logic [MAG_W-1:0]    mag;
    logic                neg;
    logic [RADIUS_W-1:0] radius;
    logic [TIME_W-1:0]   dt;
  } ewse_job_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ewse_status_t;

endpackage

// ----- rtl/encoder_wheel_speed_estimator.sv -----
// Top level of the encoder wheel speed estimator: unwrapping, window store and output word.
// The first two samples of a window are stored and give no word.
// The third starts the serial unit (a multiply by the radius, a multiply by the scale and a divide),
// whose word then goes to the output register; with a zero interval the unit skips straight to done.
// The input stalls while the unit works or holds a word, so a new window waits until the last word is taken.
// Reset is synchronous: configuration, previous reading, window slot, rotation count and output valid return to zero.
`timescale 1ns / 1ps

module encoder_wheel_speed_estimator (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 sample_valid,
  output logic                                 sample_stall,
  input  ewse_pkg::sample_word_t               sample_word,
  output logic                                 speed_valid,
  input  logic                                 speed_stall,
  output ewse_pkg::speed_word_t                speed_word,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ewse_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ewse_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic [ewse_pkg::NOISE_W-1:0]  noise_offset;
  logic [ewse_pkg::RADIUS_W-1:0] wheel_radius_um;
  logic [ewse_pkg::SAMPLE_W-1:0] prev_reading;
  logic [ewse_pkg::COUNT_W-1:0]  rot_count;
  logic [1:0]                    slot;
  logic [ewse_pkg::POS_W-1:0]    pos0;
  logic [ewse_pkg::POS_W-1:0]    pos1;
  logic [ewse_pkg::TIME_W-1:0]   time0;

  logic                          accept;
  logic signed [ewse_pkg::SAMPLE_W+1:0] threshold;
  logic                          wrap;
  logic [ewse_pkg::COUNT_W-1:0]  rot_count_next;
  logic [ewse_pkg::POS_W-1:0]    pos;
  logic [ewse_pkg::NUM_W-1:0]    num;
  logic [ewse_pkg::NUM_W-1:0]    mag_full;
  logic                          start;
  logic                          load;
  ewse_pkg::ewse_job_t           job;
  ewse_pkg::ewse_status_t        status;
  ewse_pkg::speed_word_t         result;

  assign cfg_ready = 1'b1;
  assign accept = sample_valid && !sample_stall;
  assign sample_stall = status.busy;

  always_comb begin
    threshold = $signed({2'b00, prev_reading}) - $signed({2'b00, noise_offset});
    wrap = $signed({2'b00, sample_word.sample}) < threshold;
    if (slot == 2'd0) begin
      rot_count_next = '0;
    end else if (wrap && rot_count != ewse_pkg::COUNT_MAX) begin
      rot_count_next = rot_count + 1'b1;
    end else begin
      rot_count_next = rot_count;
    end
    pos = {rot_count_next, sample_word.sample};
    num = ewse_pkg::NUM_W'({pos, 1'b0}) + ewse_pkg::NUM_W'(pos) + ewse_pkg::NUM_W'(pos0)
        - ewse_pkg::NUM_W'({pos1, 2'b00});
    mag_full = num[ewse_pkg::NUM_W-1] ? (ewse_pkg::NUM_W'(0) - num) : num;
    job.mag = mag_full[ewse_pkg::MAG_W-1:0];
    job.neg = num[ewse_pkg::NUM_W-1];
    job.radius = wheel_radius_um;
    job.dt = sample_word.timestamp_us - time0;
  end

  assign start = accept && slot == 2'd2;
  assign load = status.done && (!speed_valid || !speed_stall);

  ewse_speed_unit u_speed (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .job    (job),
    .take   (load),
    .status (status),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_offset <= '0;
      wheel_radius_um <= '0;
      prev_reading <= '0;
      rot_count <= '0;
      slot <= '0;
      speed_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ewse_pkg::REG_NOISE_OFFSET: noise_offset <= cfg_data[ewse_pkg::NOISE_W-1:0];
          ewse_pkg::REG_WHEEL_RADIUS: wheel_radius_um <= cfg_data;
          default: begin
          end
        endcase
      end
      if (accept) begin
        prev_reading <= sample_word.sample;
        rot_count <= rot_count_next;
        case (slot)
          2'd0: begin
            pos0 <= pos;
            time0 <= sample_word.timestamp_us;
            slot <= 2'd1;
          end
          2'd1: begin
            pos1 <= pos;
            slot <= 2'd2;
          end
          default: begin
            slot <= 2'd0;
          end
        endcase
      end
      if (load) begin
        speed_valid <= 1'b1;
        speed_word <= result;
      end else if (speed_valid && !speed_stall) begin
        speed_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/ewse_speed_unit.sv -----
// Serial multiply and divide unit that turns one window difference into a speed word.
`timescale 1ns / 1ps

module ewse_speed_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  ewse_pkg::ewse_job_t   job,
  input  logic                  take,
  output ewse_pkg::ewse_status_t status,
  output ewse_pkg::speed_word_t result
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t state;

  logic [ewse_pkg::PROD_W-1:0]  mcand;
  logic [ewse_pkg::SCALE_W-1:0] mbits;
  logic [ewse_pkg::PROD_W-1:0]  hi;
  logic [ewse_pkg::SCALE_W-1:0] lo;
  logic [ewse_pkg::CNT_W-1:0]   cnt;
  logic [ewse_pkg::TIME_W-1:0]  dt;
  logic                         neg;
  logic                         bad;
  logic [ewse_pkg::DVD_W-1:0]   dvd;
  logic [ewse_pkg::TIME_W-1:0]  rem;
  logic [ewse_pkg::Q2_W-1:0]    q2;
  logic                         ovf;

  logic [ewse_pkg::PROD_W:0]    sum;
  logic [ewse_pkg::N_W-1:0]     prod_next;
  logic [ewse_pkg::TIME_W:0]    rt;
  logic [ewse_pkg::TIME_W:0]    diff;
  logic                         ge;
  logic [ewse_pkg::TIME_W-1:0]  rem_next;
  logic [ewse_pkg::Q2_W:0]      qr_sum;
  logic [ewse_pkg::Q2_W-1:0]    qr;

  always_comb begin
    sum = {1'b0, hi} + (mbits[0] ? {1'b0, mcand} : {(ewse_pkg::PROD_W + 1){1'b0}});
    prod_next = {sum, lo[ewse_pkg::SCALE_W-1:1]};
    rt = {rem, dvd[ewse_pkg::DVD_W-1]};
    diff = rt - {1'b0, dt};
    ge = rt >= {1'b0, dt};
    rem_next = ge ? diff[ewse_pkg::TIME_W-1:0] : rt[ewse_pkg::TIME_W-1:0];
  end

  always_comb begin
    qr_sum = {1'b0, q2} + (ewse_pkg::Q2_W + 1)'(1);
    qr = qr_sum[ewse_pkg::Q2_W:1];
    result.bad_interval = bad;
    if (bad) begin
      result.speed_mm_s = '0;
    end else if (neg) begin
      if (ovf || qr > ewse_pkg::Q2_W'(1 << (ewse_pkg::SPEED_W - 1))) begin
        result.speed_mm_s = {1'b1, {(ewse_pkg::SPEED_W - 1){1'b0}}};
      end else begin
        result.speed_mm_s = $signed(ewse_pkg::SPEED_W'(0) - qr[ewse_pkg::SPEED_W-1:0]);
      end
    end else begin
      if (ovf || qr > ewse_pkg::Q2_W'((1 << (ewse_pkg::SPEED_W - 1)) - 1)) begin
        result.speed_mm_s = {1'b0, {(ewse_pkg::SPEED_W - 1){1'b1}}};
      end else begin
        result.speed_mm_s = $signed(qr[ewse_pkg::SPEED_W-1:0]);
      end
    end
  end

  assign status.busy = state != ST_IDLE;
  assign status.done = state == ST_DONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            dt <= job.dt;
            neg <= job.neg;
            if (job.dt == '0) begin
              bad <= 1'b1;
              state <= ST_DONE;
            end else begin
              bad <= 1'b0;
              mcand <= ewse_pkg::PROD_W'(job.radius);
              mbits <= ewse_pkg::SCALE_W'(job.mag);
              hi <= '0;
              lo <= '0;
              cnt <= ewse_pkg::CNT_W'(ewse_pkg::MAG_W - 1);
              state <= ST_MUL1;
            end
          end
        end
        ST_MUL1: begin
          if (cnt == '0) begin
            mcand <= prod_next[ewse_pkg::SCALE_W - ewse_pkg::MAG_W +: ewse_pkg::PROD_W];
            mbits <= ewse_pkg::SCALE;
            hi <= '0;
            lo <= '0;
            cnt <= ewse_pkg::CNT_W'(ewse_pkg::SCALE_W - 1);
            state <= ST_MUL2;
          end else begin
            hi <= prod_next[ewse_pkg::N_W-1:ewse_pkg::SCALE_W];
            lo <= prod_next[ewse_pkg::SCALE_W-1:0];
            mbits <= mbits >> 1;
            cnt <= cnt - 1'b1;
          end
        end
        ST_MUL2: begin
          if (cnt == '0) begin
            dvd <= prod_next[ewse_pkg::N_W-1 -: ewse_pkg::DVD_W];
            rem <= '0;
            q2 <= '0;
            ovf <= 1'b0;
            cnt <= ewse_pkg::CNT_W'(ewse_pkg::DVD_W - 1);
            state <= ST_DIV;
          end else begin
            hi <= prod_next[ewse_pkg::N_W-1:ewse_pkg::SCALE_W];
            lo <= prod_next[ewse_pkg::SCALE_W-1:0];
            mbits <= mbits >> 1;
            cnt <= cnt - 1'b1;
          end
        end
        ST_DIV: begin
          rem <= rem_next;
          dvd <= dvd << 1;
          q2 <= {q2[ewse_pkg::Q2_W-2:0], ge};
          ovf <= ovf | q2[ewse_pkg::Q2_W-1];
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (take) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the encoder wheel speed estimator, with a directed table and random windows.
`timescale 1ns / 1ps

module tb;
  import ewse_pkg::*;

  localparam int SETTLE_CYCLES = 100;
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int WINDOW_LEN = 3;
  localparam int RANDOM_WINDOWS = 70;
  localparam logic [POS_W-1:0] COUNTS_PER_TURN = 12'd1024;
  localparam logic [63:0] MILLI_TWO_PI_Q14 = 64'd102944000;
  localparam logic [63:0] SPEED_TOP = 64'd1048575;
  localparam logic [63:0] SPEED_BOTTOM_MAG = 64'd1048576;

  typedef enum bit {ROW_SAMPLE, ROW_CONFIG} row_kind_e;
  typedef enum {WIN_RAMP, WIN_NOISE, WIN_FAST, WIN_FLAT} window_kind_e;

  typedef struct {
    row_kind_e           kind;
    logic [SAMPLE_W-1:0] value;
    logic [TIME_W-1:0]   stamp;
    bit                  typed;
    speed_word_t         word;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_stall;
  sample_word_t sample_word = '0;
  logic speed_valid;
  logic speed_stall = 1'b0;
  speed_word_t speed_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [NOISE_W-1:0] noise_cfg = '0;
  logic [RADIUS_W-1:0] radius_cfg = '0;
  logic [SAMPLE_W-1:0] last_reading = '0;
  logic [COUNT_W-1:0] turns = '0;
  int slot = 0;
  logic [POS_W-1:0] win_pos [WINDOW_LEN];
  logic [TIME_W-1:0] win_time [WINDOW_LEN];

  speed_word_t pending_speeds [$];
  speed_word_t head_word;
  int mismatches = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_ask = 1'b0;
  int hold_count = 0;

  encoder_wheel_speed_estimator i_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_word  (sample_word),
    .speed_valid  (speed_valid),
    .speed_stall  (speed_stall),
    .speed_word   (speed_word),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic bit advance_window(input sample_word_t w, output speed_word_t res);
    int thresh;
    int num;
    logic [TIME_W-1:0] dt;
    logic [63:0] mag, n, d, q, r;
    res = '0;
    thresh = int'(last_reading) - int'(noise_cfg);
    if (int'(w.sample) < thresh && turns != COUNT_MAX) turns++;
    if (slot == 0) turns = '0;
    last_reading = w.sample;
    win_pos[slot] = POS_W'(w.sample) + POS_W'(turns) * COUNTS_PER_TURN;
    win_time[slot] = w.timestamp_us;
    if (slot != WINDOW_LEN - 1) begin
      slot++;
      return 1'b0;
    end
    slot = 0;
    num = 3 * int'(win_pos[2]) - 4 * int'(win_pos[1]) + int'(win_pos[0]);
    dt = win_time[2] - win_time[0];
    if (dt == '0) begin
      res.bad_interval = 1'b1;
      return 1'b1;
    end
    mag = 64'(num < 0 ? -num : num);
    n = mag * 64'(radius_cfg) * MILLI_TWO_PI_Q14;
    d = 64'(dt) << 24;
    q = n / d;
    r = n % d;
    if (r >= d - r) q++;
    if (num < 0) begin
      if (q > SPEED_BOTTOM_MAG) q = SPEED_BOTTOM_MAG;
      res.speed_mm_s = SPEED_W'(64'd0 - q);
    end else begin
      if (q > SPEED_TOP) q = SPEED_TOP;
      res.speed_mm_s = SPEED_W'(q);
    end
    return 1'b1;
  endfunction

  task automatic log_mismatch(input string what, input longint want_v, input longint got_v);
    mismatches++;
    if (mismatches <= 10) $display("mismatch in %s: expected %0d, got %0d", what, want_v, got_v);
  endtask

  task automatic push_sample(input sample_word_t w, input bit typed, input speed_word_t typed_word);
    speed_word_t due;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_word <= w;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    if (advance_window(w, due)) pending_speeds.push_back(typed ? typed_word : due);
  endtask

  task automatic set_config(input logic [NOISE_W-1:0] noise, input logic [RADIUS_W-1:0] radius);
    sample_valid <= 1'b0;
    while (pending_speeds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= REG_NOISE_OFFSET;
    cfg_data <= CFG_DATA_W'(noise);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_WHEEL_RADIUS;
    cfg_data <= CFG_DATA_W'(radius);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    noise_cfg = noise;
    radius_cfg = radius;
  endtask

  always @(posedge clk) begin
    if (hold_ask && hold_count < HOLD_CYCLES) begin
      speed_stall <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      speed_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if ((sample_valid && !sample_stall) || (speed_valid && !speed_stall) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (speed_valid && !speed_stall) begin
        if (pending_speeds.size() == 0) begin
          log_mismatch("word with none pending, speed_mm_s", 0, speed_word.speed_mm_s);
        end else begin
          head_word = pending_speeds.pop_front();
          if (speed_word.speed_mm_s !== head_word.speed_mm_s)
            log_mismatch("speed_mm_s", head_word.speed_mm_s, speed_word.speed_mm_s);
          if (speed_word.bad_interval !== head_word.bad_interval)
            log_mismatch("bad_interval", head_word.bad_interval, speed_word.bad_interval);
        end
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    plan_row_t plan [24];
    sample_word_t w;
    window_kind_e kind;
    int step;
    int walk;
    logic [TIME_W-1:0] clock_us;
    logic [TIME_W-1:0] first_ts;

    plan = '{
      '{ROW_SAMPLE, 10'd100, 32'd1000, 1'b0, '0},
      '{ROW_SAMPLE, 10'd200, 32'd2000, 1'b0, '0},
      '{ROW_SAMPLE, 10'd300, 32'd3000, 1'b1, '{21'sd0, 1'b0}},
      '{ROW_SAMPLE, 10'd5, 32'd5000, 1'b0, '0},
      '{ROW_SAMPLE, 10'd6, 32'd6000, 1'b0, '0},
      '{ROW_SAMPLE, 10'd7, 32'd5000, 1'b1, '{21'sd0, 1'b1}},
      '{ROW_CONFIG, 10'd0, 32'd1048575, 1'b0, '0},
      '{ROW_SAMPLE, 10'd0, 32'hFFFFFFFF, 1'b0, '0},
      '{ROW_SAMPLE, 10'd0, 32'd0, 1'b0, '0},
      '{ROW_SAMPLE, 10'd1023, 32'd0, 1'b1, '{21'sd1048575, 1'b0}},
      '{ROW_SAMPLE, 10'd0, 32'd10, 1'b0, '0},
      '{ROW_SAMPLE, 10'd1023, 32'd10, 1'b0, '0},
      '{ROW_SAMPLE, 10'd1023, 32'd11, 1'b1, '{21'h100000, 1'b0}},
      '{ROW_SAMPLE, 10'd1000, 32'd100000, 1'b0, '0},
      '{ROW_SAMPLE, 10'd10, 32'd1100000, 1'b0, '0},
      '{ROW_SAMPLE, 10'd5, 32'd1200000, 1'b0, '0},
      '{ROW_CONFIG, 10'd1023, 32'd1000, 1'b0, '0},
      '{ROW_SAMPLE, 10'd500, 32'd7, 1'b0, '0},
      '{ROW_SAMPLE, 10'd400, 32'd8, 1'b0, '0},
      '{ROW_SAMPLE, 10'd300, 32'd9, 1'b0, '0},
      '{ROW_CONFIG, 10'd50, 32'd250000, 1'b0, '0},
      '{ROW_SAMPLE, 10'd500, 32'hFFFFFF00, 1'b0, '0},
      '{ROW_SAMPLE, 10'd480, 32'hFFFFFFF0, 1'b0, '0},
      '{ROW_SAMPLE, 10'd100, 32'h00000100, 1'b0, '0}
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CONFIG) begin
        set_config(plan[i].value, plan[i].stamp[RADIUS_W-1:0]);
      end else begin
        w.sample = plan[i].value;
        w.timestamp_us = plan[i].stamp;
        push_sample(w, plan[i].typed, plan[i].word);
      end
    end

    walk = $urandom_range(0, 1023);
    clock_us = $urandom;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_config(NOISE_W'(1023), RADIUS_W'(1048575));
        1: set_config(NOISE_W'(0), RADIUS_W'($urandom_range(0, 1048575)));
        default: set_config(NOISE_W'($urandom_range(0, 1) ? $urandom_range(0, 63)
                                                          : $urandom_range(0, 1023)),
                            RADIUS_W'($urandom_range(0, 1048575)));
      endcase
      case (phase)
        1: begin send_idle_pct = 83; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 83; end
        3: begin send_idle_pct = 21; stall_pct = 21; end
        default: begin send_idle_pct = 0; stall_pct = 0; end
      endcase
      for (int n = 0; n < RANDOM_WINDOWS; n++) begin
        if (phase == 0 && n == 20) hold_ask <= 1'b1;
        case ($urandom_range(0, 9))
          7: kind = WIN_NOISE;
          8: kind = WIN_FAST;
          9: kind = WIN_FLAT;
          default: kind = WIN_RAMP;
        endcase
        if ($urandom_range(0, 3) == 0) step = int'($urandom_range(0, 1023)) - 512;
        else step = int'($urandom_range(0, 160)) - 80;
        for (int k = 0; k < WINDOW_LEN; k++) begin
          if (kind == WIN_NOISE) begin
            w.sample = SAMPLE_W'($urandom);
            w.timestamp_us = $urandom;
          end else begin
            walk = walk + step + int'($urandom_range(0, 6)) - 3;
            w.sample = SAMPLE_W'(walk);
            if (kind == WIN_FAST) clock_us = clock_us + 1;
            else clock_us = clock_us + $urandom_range(200, 3000);
            if (k == 0) first_ts = clock_us;
            w.timestamp_us = (kind == WIN_FLAT && k == WINDOW_LEN - 1) ? first_ts : clock_us;
          end
          push_sample(w, 1'b0, '0);
        end
      end
    end

    sample_valid <= 1'b0;
    while (pending_speeds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/ewse_pkg.sv
rtl/ewse_speed_unit.sv
rtl/encoder_wheel_speed_estimator.sv
tb/tb.sv
